@@ design/hpack_pkg.sv @@
package hpack_pkg;

    localparam int CODE_MAX_LEN = 30;
    localparam int LEN_W = 5;
    localparam int OFFSET_W = 3;
    localparam int PEND_W = 7;
    // 7 pending bits plus the longest code, rounded up to whole bytes
    localparam int WIN_W = 40;
    localparam int NBYTES_W = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } t_sym_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_byte_out;

    // bytes of one request, left aligned, first byte in the top bits
    typedef struct packed {
        logic [WIN_W-1:0]    bits;
        logic [NBYTES_W-1:0] nbytes;
        logic                last;
    } t_seg;

    // static huffman table, codes right aligned
    localparam logic [31:0] HUFF_CODE [256] = '{
        32'h1ff8, 32'h7fffd8, 32'hfffffe2, 32'hfffffe3,
        32'hfffffe4, 32'hfffffe5, 32'hfffffe6, 32'hfffffe7,
        32'hfffffe8, 32'hffffea, 32'h3ffffffc, 32'hfffffe9,
        32'hfffffea, 32'h3ffffffd, 32'hfffffeb, 32'hfffffec,
        32'hfffffed, 32'hfffffee, 32'hfffffef, 32'hffffff0,
        32'hffffff1, 32'hffffff2, 32'h3ffffffe, 32'hffffff3,
        32'hffffff4, 32'hffffff5, 32'hffffff6, 32'hffffff7,
        32'hffffff8, 32'hffffff9, 32'hffffffa, 32'hffffffb,
        32'h14, 32'h3f8, 32'h3f9, 32'hffa, 32'h1ff9, 32'h15, 32'hf8, 32'h7fa,
        32'h3fa, 32'h3fb, 32'hf9, 32'h7fb, 32'hfa, 32'h16, 32'h17, 32'h18,
        32'h0, 32'h1, 32'h2, 32'h19, 32'h1a, 32'h1b, 32'h1c, 32'h1d,
        32'h1e, 32'h1f, 32'h5c, 32'hfb, 32'h7ffc, 32'h20, 32'hffb, 32'h3fc,
        32'h1ffa, 32'h21, 32'h5d, 32'h5e, 32'h5f, 32'h60, 32'h61, 32'h62,
        32'h63, 32'h64, 32'h65, 32'h66, 32'h67, 32'h68, 32'h69, 32'h6a,
        32'h6b, 32'h6c, 32'h6d, 32'h6e, 32'h6f, 32'h70, 32'h71, 32'h72,
        32'hfc, 32'h73, 32'hfd, 32'h1ffb, 32'h7fff0, 32'h1ffc, 32'h3ffc, 32'h22,
        32'h7ffd, 32'h3, 32'h23, 32'h4, 32'h24, 32'h5, 32'h25, 32'h26,
        32'h27, 32'h6, 32'h74, 32'h75, 32'h28, 32'h29, 32'h2a, 32'h7,
        32'h2b, 32'h76, 32'h2c, 32'h8, 32'h9, 32'h2d, 32'h77, 32'h78,
        32'h79, 32'h7a, 32'h7b, 32'h7ffe, 32'h7fc, 32'h3ffd, 32'h1ffd, 32'hffffffc,
        32'hfffe6, 32'h3fffd2, 32'hfffe7, 32'hfffe8,
        32'h3fffd3, 32'h3fffd4, 32'h3fffd5, 32'h7fffd9,
        32'h3fffd6, 32'h7fffda, 32'h7fffdb, 32'h7fffdc,
        32'h7fffdd, 32'h7fffde, 32'hffffeb, 32'h7fffdf,
        32'hffffec, 32'hffffed, 32'h3fffd7, 32'h7fffe0,
        32'hffffee, 32'h7fffe1, 32'h7fffe2, 32'h7fffe3,
        32'h7fffe4, 32'h1fffdc, 32'h3fffd8, 32'h7fffe5,
        32'h3fffd9, 32'h7fffe6, 32'h7fffe7, 32'hffffef,
        32'h3fffda, 32'h1fffdd, 32'hfffe9, 32'h3fffdb,
        32'h3fffdc, 32'h7fffe8, 32'h7fffe9, 32'h1fffde,
        32'h7fffea, 32'h3fffdd, 32'h3fffde, 32'hfffff0,
        32'h1fffdf, 32'h3fffdf, 32'h7fffeb, 32'h7fffec,
        32'h1fffe0, 32'h1fffe1, 32'h3fffe0, 32'h1fffe2,
        32'h7fffed, 32'h3fffe1, 32'h7fffee, 32'h7fffef,
        32'hfffea, 32'h3fffe2, 32'h3fffe3, 32'h3fffe4,
        32'h7ffff0, 32'h3fffe5, 32'h3fffe6, 32'h7ffff1,
        32'h3ffffe0, 32'h3ffffe1, 32'hfffeb, 32'h7fff1,
        32'h3fffe7, 32'h7ffff2, 32'h3fffe8, 32'h1ffffec,
        32'h3ffffe2, 32'h3ffffe3, 32'h3ffffe4, 32'h7ffffde,
        32'h7ffffdf, 32'h3ffffe5, 32'hfffff1, 32'h1ffffed,
        32'h7fff2, 32'h1fffe3, 32'h3ffffe6, 32'h7ffffe0,
        32'h7ffffe1, 32'h3ffffe7, 32'h7ffffe2, 32'hfffff2,
        32'h1fffe4, 32'h1fffe5, 32'h3ffffe8, 32'h3ffffe9,
        32'hffffffd, 32'h7ffffe3, 32'h7ffffe4, 32'h7ffffe5,
        32'hfffec, 32'hfffff3, 32'hfffed, 32'h1fffe6,
        32'h3fffe9, 32'h1fffe7, 32'h1fffe8, 32'h7ffff3,
        32'h3fffea, 32'h3fffeb, 32'h1ffffee, 32'h1ffffef,
        32'hfffff4, 32'hfffff5, 32'h3ffffea, 32'h7ffff4,
        32'h3ffffeb, 32'h7ffffe6, 32'h3ffffec, 32'h3ffffed,
        32'h7ffffe7, 32'h7ffffe8, 32'h7ffffe9, 32'h7ffffea,
        32'h7ffffeb, 32'hffffffe, 32'h7ffffec, 32'h7ffffed,
        32'h7ffffee, 32'h7ffffef, 32'h7fffff0, 32'h3ffffee
    };

    localparam logic [7:0] HUFF_LEN [256] = '{
        8'd13, 8'd23, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28,
        8'd28, 8'd24, 8'd30, 8'd28, 8'd28, 8'd30, 8'd28, 8'd28,
        8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd30, 8'd28,
        8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28,
        8'd6, 8'd10, 8'd10, 8'd12, 8'd13, 8'd6, 8'd8, 8'd11,
        8'd10, 8'd10, 8'd8, 8'd11, 8'd8, 8'd6, 8'd6, 8'd6,
        8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6,
        8'd6, 8'd6, 8'd7, 8'd8, 8'd15, 8'd6, 8'd12, 8'd10,
        8'd13, 8'd6, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7,
        8'd8, 8'd7, 8'd8, 8'd13, 8'd19, 8'd13, 8'd14, 8'd6,
        8'd15, 8'd5, 8'd6, 8'd5, 8'd6, 8'd5, 8'd6, 8'd6,
        8'd6, 8'd5, 8'd7, 8'd7, 8'd6, 8'd6, 8'd6, 8'd5,
        8'd6, 8'd7, 8'd6, 8'd5, 8'd5, 8'd6, 8'd7, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd15, 8'd11, 8'd14, 8'd13, 8'd28,
        8'd20, 8'd22, 8'd20, 8'd20, 8'd22, 8'd22, 8'd22, 8'd23,
        8'd22, 8'd23, 8'd23, 8'd23, 8'd23, 8'd23, 8'd24, 8'd23,
        8'd24, 8'd24, 8'd22, 8'd23, 8'd24, 8'd23, 8'd23, 8'd23,
        8'd23, 8'd21, 8'd22, 8'd23, 8'd22, 8'd23, 8'd23, 8'd24,
        8'd22, 8'd21, 8'd20, 8'd22, 8'd22, 8'd23, 8'd23, 8'd21,
        8'd23, 8'd22, 8'd22, 8'd24, 8'd21, 8'd22, 8'd23, 8'd23,
        8'd21, 8'd21, 8'd22, 8'd21, 8'd23, 8'd22, 8'd23, 8'd23,
        8'd20, 8'd22, 8'd22, 8'd22, 8'd23, 8'd22, 8'd22, 8'd23,
        8'd26, 8'd26, 8'd20, 8'd19, 8'd22, 8'd23, 8'd22, 8'd25,
        8'd26, 8'd26, 8'd26, 8'd27, 8'd27, 8'd26, 8'd24, 8'd25,
        8'd19, 8'd21, 8'd26, 8'd27, 8'd27, 8'd26, 8'd27, 8'd24,
        8'd21, 8'd21, 8'd26, 8'd26, 8'd28, 8'd27, 8'd27, 8'd27,
        8'd20, 8'd24, 8'd20, 8'd21, 8'd22, 8'd21, 8'd21, 8'd23,
        8'd22, 8'd22, 8'd25, 8'd25, 8'd24, 8'd24, 8'd26, 8'd23,
        8'd26, 8'd27, 8'd26, 8'd26, 8'd27, 8'd27, 8'd27, 8'd27,
        8'd27, 8'd28, 8'd27, 8'd27, 8'd27, 8'd27, 8'd27, 8'd26
    };

endpackage

@@ design/hpack_front.sv @@
module hpack_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  hpack_pkg::t_sym_in         i_in_data,
    input  logic                       i_cfg_we,
    input  logic [hpack_pkg::OFFSET_W-1:0] i_cfg_data,
    input  logic                       i_q_ready,
    output logic                       o_push,
    output hpack_pkg::t_seg            o_seg
);
    import hpack_pkg::*;

    localparam int ACC_W = PEND_W + CODE_MAX_LEN;
    localparam int TOT_W = $clog2(ACC_W + 1);

    logic [OFFSET_W-1:0]     r_offset;
    logic [PEND_W-1:0]       r_pbits, n_pbits;
    logic [OFFSET_W-1:0]     r_pcount, n_pcount;
    logic                    r_inside, n_inside;

    logic [CODE_MAX_LEN-1:0] code;
    logic [LEN_W-1:0]        len;
    logic [OFFSET_W-1:0]     cnt;
    logic [PEND_W-1:0]       pend;
    logic [ACC_W-1:0]        acc;
    logic [TOT_W-1:0]        total;
    logic [OFFSET_W-1:0]     rem;
    logic [WIN_W-1:0]        aligned;
    logic [WIN_W-1:0]        pad_mask;
    logic                    accept;

    assign code = HUFF_CODE[i_in_data.symbol][CODE_MAX_LEN-1:0];
    assign len  = HUFF_LEN[i_in_data.symbol][LEN_W-1:0];

    // a new string starts with offset zero bits already in the byte
    assign cnt  = r_inside ? r_pcount : r_offset;
    assign pend = r_inside ? r_pbits : '0;

    assign acc      = (ACC_W'(pend) << len) | ACC_W'(code);
    assign total    = TOT_W'(cnt) + TOT_W'(len);
    assign rem      = total[OFFSET_W-1:0];
    assign aligned  = WIN_W'(acc) << (TOT_W'(WIN_W) - total);
    // eos prefix is all ones
    assign pad_mask = {WIN_W{1'b1}} >> total;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = i_q_ready;

    always_comb begin
        o_seg.bits   = i_in_data.last_symbol ? (aligned | pad_mask) : aligned;
        o_seg.nbytes = NBYTES_W'(total >> OFFSET_W)
                     + NBYTES_W'(i_in_data.last_symbol && (rem != '0));
        o_seg.last   = i_in_data.last_symbol;
    end

    // items that only top up the pending bits make no request
    assign o_push = accept && (o_seg.nbytes != '0);

    always_comb begin
        n_pbits  = r_pbits;
        n_pcount = r_pcount;
        n_inside = r_inside;
        if (accept) begin
            if (i_in_data.last_symbol) begin
                n_pbits  = '0;
                n_pcount = '0;
                n_inside = 1'b0;
            end else begin
                n_pbits  = acc[PEND_W-1:0] & ({PEND_W{1'b1}} >> (OFFSET_W'(PEND_W) - rem));
                n_pcount = rem;
                n_inside = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_pbits  <= '0;
            r_pcount <= '0;
            r_inside <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_data;
            end
            r_pbits  <= n_pbits;
            r_pcount <= n_pcount;
            r_inside <= n_inside;
        end
    end

endmodule

@@ design/hpack_queue.sv @@
module hpack_queue #(
    parameter int DEPTH = hpack_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hpack_pkg::t_seg i_seg,
    output logic            o_ready,
    output logic            o_valid,
    output hpack_pkg::t_seg o_head,
    input  logic            i_pop
);
    import hpack_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_seg             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ design/hpack_back.sv @@
module hpack_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  hpack_pkg::t_seg      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hpack_pkg::t_byte_out o_out_data
);
    import hpack_pkg::*;

    logic [NBYTES_W-1:0] r_idx, n_idx;
    logic                r_valid, n_valid;
    t_byte_out           r_data;
    logic [WIN_W-1:0]    shifted;
    logic                load;
    logic                at_end;

    assign shifted = i_head.bits << {r_idx, 3'b000};
    assign at_end  = (r_idx == i_head.nbytes - 1'b1);
    // output register refills whenever the queue has a request and the register is empty or being taken
    assign load    = i_q_valid && (!r_valid || i_out_ready);
    assign o_pop   = load && at_end;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = at_end ? '0 : r_idx + 1'b1;
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_byte  <= shifted[WIN_W-1 -: 8];
            r_data.last_byte <= i_head.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ design/hpack_huffman_encoder.sv @@
// hpack static huffman string encoder
// input channel (i_in_valid/o_in_ready): one string octet per request, with
// last_symbol set on the final octet of the string.
// output channel (o_out_valid/i_out_ready): encoded bytes, first bit in the
// msb; last_byte marks the final byte of the string, padded with ones.
// i_cfg_we/i_cfg_data set the number of zero bit positions that open the
// first byte of a string; it is picked up when the next string starts.
// the front end looks up the code and packs it with the pending bits
// combinationally, so it takes an octet every cycle while the queue has room.
// the back end sends one byte per cycle while the receiver takes them, so throughput
// is set by the output port: an octet yields as many output bytes as it completes
// (0 to 5, 2 to 5 for long codes); short codes often yield none and only fill bits.
// the first byte of an octet goes through the queue and then the output register.
// when the receiver stalls the output byte holds, the queue fills and then
// o_in_ready drops. reset clears the pending bits, the queue and the offset.
module hpack_huffman_encoder #(
    parameter int QUEUE_DEPTH = hpack_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hpack_pkg::t_sym_in             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hpack_pkg::t_byte_out           o_out_data,
    input  logic                           i_cfg_we,
    input  logic [hpack_pkg::OFFSET_W-1:0] i_cfg_data
);
    import hpack_pkg::*;

    logic q_ready;
    logic push;
    t_seg seg;
    logic q_valid;
    t_seg head;
    logic pop;

    hpack_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_seg      (seg)
    );

    hpack_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (seg),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    hpack_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ design/hpack_checker.sv @@
module hpack_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input hpack_pkg::t_sym_in             i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input hpack_pkg::t_byte_out           o_out_data,
    input logic                           i_cfg_we,
    input logic [hpack_pkg::OFFSET_W-1:0] i_cfg_data
);
    import hpack_pkg::*;

    logic [7:0] r_open;
    logic       in_end;
    logic       out_end;

    assign in_end  = i_in_valid && o_in_ready && i_in_data.last_symbol;
    assign out_end = o_out_valid && i_out_ready && o_out_data.last_byte;

    // strings whose last octet went in but whose last byte has not come out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 8'(in_end) - 8'(out_end);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output byte changed");

    a_last_has_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_end |-> (r_open != '0))
        else $error("last byte without a finished string");

    a_backpressure_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled while output is empty");

    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && i_cfg_we |-> $past(r_open) == r_open || out_end
            || $past(out_end) || $past(in_end))
        else $error("config write changed string tracking");

endmodule

bind hpack_huffman_encoder hpack_checker u_hpack_checker (.*);

@@ test/hpack_huffman_encoder_checker.sv @@
module hpack_huffman_encoder_checker
    import hpack_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_sym_in             i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_byte_out           i_out_data,
    input  logic                i_cfg_we,
    input  logic [OFFSET_W-1:0] i_cfg_data,
    output int                  o_mismatch_count,
    output int                  o_bytes_due
);

    // rfc 7541 appendix b, codes right aligned
    localparam logic [29:0] CODE_BITS [256] = '{
        'h1ff8, 'h7fffd8, 'hfffffe2, 'hfffffe3, 'hfffffe4, 'hfffffe5, 'hfffffe6, 'hfffffe7,
        'hfffffe8, 'hffffea, 'h3ffffffc, 'hfffffe9, 'hfffffea, 'h3ffffffd, 'hfffffeb,
        'hfffffec, 'hfffffed, 'hfffffee, 'hfffffef, 'hffffff0, 'hffffff1, 'hffffff2,
        'h3ffffffe, 'hffffff3, 'hffffff4, 'hffffff5, 'hffffff6, 'hffffff7, 'hffffff8,
        'hffffff9, 'hffffffa, 'hffffffb,
        'h14, 'h3f8, 'h3f9, 'hffa, 'h1ff9, 'h15, 'hf8, 'h7fa,
        'h3fa, 'h3fb, 'hf9, 'h7fb, 'hfa, 'h16, 'h17, 'h18,
        'h0, 'h1, 'h2, 'h19, 'h1a, 'h1b, 'h1c, 'h1d,
        'h1e, 'h1f, 'h5c, 'hfb, 'h7ffc, 'h20, 'hffb, 'h3fc,
        'h1ffa, 'h21, 'h5d, 'h5e, 'h5f, 'h60, 'h61, 'h62,
        'h63, 'h64, 'h65, 'h66, 'h67, 'h68, 'h69, 'h6a,
        'h6b, 'h6c, 'h6d, 'h6e, 'h6f, 'h70, 'h71, 'h72,
        'hfc, 'h73, 'hfd, 'h1ffb, 'h7fff0, 'h1ffc, 'h3ffc, 'h22,
        'h7ffd, 'h3, 'h23, 'h4, 'h24, 'h5, 'h25, 'h26,
        'h27, 'h6, 'h74, 'h75, 'h28, 'h29, 'h2a, 'h7,
        'h2b, 'h76, 'h2c, 'h8, 'h9, 'h2d, 'h77, 'h78,
        'h79, 'h7a, 'h7b, 'h7ffe, 'h7fc, 'h3ffd, 'h1ffd, 'hffffffc,
        'hfffe6, 'h3fffd2, 'hfffe7, 'hfffe8, 'h3fffd3, 'h3fffd4, 'h3fffd5, 'h7fffd9,
        'h3fffd6, 'h7fffda, 'h7fffdb, 'h7fffdc, 'h7fffdd, 'h7fffde, 'hffffeb, 'h7fffdf,
        'hffffec, 'hffffed, 'h3fffd7, 'h7fffe0, 'hffffee, 'h7fffe1, 'h7fffe2, 'h7fffe3,
        'h7fffe4, 'h1fffdc, 'h3fffd8, 'h7fffe5, 'h3fffd9, 'h7fffe6, 'h7fffe7, 'hffffef,
        'h3fffda, 'h1fffdd, 'hfffe9, 'h3fffdb, 'h3fffdc, 'h7fffe8, 'h7fffe9, 'h1fffde,
        'h7fffea, 'h3fffdd, 'h3fffde, 'hfffff0, 'h1fffdf, 'h3fffdf, 'h7fffeb, 'h7fffec,
        'h1fffe0, 'h1fffe1, 'h3fffe0, 'h1fffe2, 'h7fffed, 'h3fffe1, 'h7fffee, 'h7fffef,
        'hfffea, 'h3fffe2, 'h3fffe3, 'h3fffe4, 'h7ffff0, 'h3fffe5, 'h3fffe6, 'h7ffff1,
        'h3ffffe0, 'h3ffffe1, 'hfffeb, 'h7fff1, 'h3fffe7, 'h7ffff2, 'h3fffe8, 'h1ffffec,
        'h3ffffe2, 'h3ffffe3, 'h3ffffe4, 'h7ffffde, 'h7ffffdf, 'h3ffffe5, 'hfffff1,
        'h1ffffed, 'h7fff2, 'h1fffe3, 'h3ffffe6, 'h7ffffe0, 'h7ffffe1, 'h3ffffe7,
        'h7ffffe2, 'hfffff2, 'h1fffe4, 'h1fffe5, 'h3ffffe8, 'h3ffffe9, 'hffffffd,
        'h7ffffe3, 'h7ffffe4, 'h7ffffe5, 'hfffec, 'hfffff3, 'hfffed, 'h1fffe6,
        'h3fffe9, 'h1fffe7, 'h1fffe8, 'h7ffff3, 'h3fffea, 'h3fffeb, 'h1ffffee, 'h1ffffef,
        'hfffff4, 'hfffff5, 'h3ffffea, 'h7ffff4, 'h3ffffeb, 'h7ffffe6, 'h3ffffec,
        'h3ffffed, 'h7ffffe7, 'h7ffffe8, 'h7ffffe9, 'h7ffffea, 'h7ffffeb, 'hffffffe,
        'h7ffffec, 'h7ffffed, 'h7ffffee, 'h7ffffef, 'h7fffff0, 'h3ffffee
    };

    localparam logic [4:0] HUFF_NBITS [256] = '{
        13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
        28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
        6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
        5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
        13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
        7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
        15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
        6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
        20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
        24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
        22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
        21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
        26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
        19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
        20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
        26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
    };

    logic [OFFSET_W-1:0] offset_reg;
    logic [PEND_W-1:0]   carry_bits;
    int                  carry_count;
    logic                in_string;
    t_byte_out           expected_bytes[$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    // append one octet's code to the carried bits and queue every finished byte
    task automatic encode_octet(input t_sym_in req);
        logic [63:0] acc;
        int          total;
        int          fill;
        int          nbytes;
        t_byte_out   made [5];

        nbytes = 0;
        if (!in_string) begin
            carry_bits  = '0;
            carry_count = int'(offset_reg);
            in_string   = 1'b1;
        end
        acc   = (64'(carry_bits) << HUFF_NBITS[req.symbol]) | 64'(CODE_BITS[req.symbol]);
        total = carry_count + int'(HUFF_NBITS[req.symbol]);
        while (total >= 8) begin
            total = total - 8;
            made[nbytes].out_byte  = 8'(acc >> total);
            made[nbytes].last_byte = 1'b0;
            nbytes++;
        end
        acc = acc & ((64'd1 << total) - 64'd1);
        if (req.last_symbol) begin
            // partial byte is closed with the leading ones of eos
            if (total > 0) begin
                fill = 8 - total;
                made[nbytes].out_byte  = 8'((acc << fill) | ((64'd1 << fill) - 64'd1));
                made[nbytes].last_byte = 1'b0;
                nbytes++;
            end
            made[nbytes-1].last_byte = 1'b1;
            carry_bits  = '0;
            carry_count = 0;
            in_string   = 1'b0;
        end else begin
            carry_bits  = acc[PEND_W-1:0];
            carry_count = total;
        end
        for (int k = 0; k < nbytes; k++) begin
            expected_bytes.push_back(made[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_byte_out want;

        if (!i_rst_n) begin
            offset_reg       = '0;
            carry_bits       = '0;
            carry_count      = 0;
            in_string        = 1'b0;
            o_mismatch_count = 0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                offset_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                encode_octet(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              i_out_data.out_byte, i_out_data.last_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_out_data.out_byte, want.out_byte));
                    end
                    if (i_out_data.last_byte !== want.last_byte) begin
                        report_mismatch($sformatf("last_byte %0b, expected %0b",
                                                  i_out_data.last_byte, want.last_byte));
                    end
                end
            end
        end
        o_bytes_due = expected_bytes.size();
    end

endmodule

@@ test/hpack_huffman_encoder_tb.sv @@
module hpack_huffman_encoder_tb;
    import hpack_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_OCTETS  = 52;

    typedef enum int {RX_FREE, RX_HALF, RX_ALTERNATE, RX_BLOCKED} t_rx_mode;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_sym_in             in_data;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_byte_out           out_data;
    logic                cfg_we;
    logic [OFFSET_W-1:0] cfg_data;
    int                  mismatch_count;
    int                  bytes_due;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    logic                sender_gaps = 1'b1;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hpack_huffman_encoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    hpack_huffman_encoder_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_data       (out_data),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_bytes_due      (bytes_due)
    );

    // receiver: segments of free flow, random stalls, every other cycle, or blocked
    always @(negedge clk) begin
        static t_rx_mode rx_mode = RX_FREE;
        static int rx_left = 0;

        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 12) : $urandom_range(8, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:      out_ready <= 1'b1;
            RX_HALF:      out_ready <= 1'($urandom_range(0, 1));
            RX_ALTERNATE: out_ready <= 1'(rx_left % 2);
            default:      out_ready <= 1'b0;
        endcase
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_octet(input logic [7:0] sym, input logic last);
        int gap;

        if (burst_left == 0) begin
            gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid         <= 1'b1;
        in_data.symbol      <= sym;
        in_data.last_symbol <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // hold requests until every queued byte is out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bytes_due != 0) @(negedge clk);
    endtask

    task automatic set_offset(input logic [OFFSET_W-1:0] value);
        wait_drained();
        // a short code may still sit in the pipe without a byte queued
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_symbol();
        int r;

        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 8'($urandom_range(8'h20, 8'h7e));
        end else if (r < 8) begin
            return 8'($urandom_range(0, 255));
        end else if (r == 8) begin
            return 8'($urandom_range(0, 31));
        end
        return 8'($urandom_range(128, 255));
    endfunction

    initial begin
        static int phase_offset [8] = '{0, 7, 4, 1, 6, 2, 5, 3};
        int sent;
        int str_len;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // offset from reset, padded two byte code
        send_octet(8'h00, 1'b1);
        // longest run: 7 offset bits plus a 26 bit code gives four bytes and a pad
        set_offset(3'd7);
        send_octet(8'hff, 1'b1);
        // 30 bit code after two offset bits fills four bytes exactly
        set_offset(3'd2);
        send_octet(8'h0a, 1'b1);
        set_offset(3'd0);
        send_octet(8'h26, 1'b1);
        send_octet(8'h30, 1'b1);
        send_octet(8'h61, 1'b0);
        send_octet(8'h30, 1'b0);
        send_octet(8'h62, 1'b1);
        // offset changed in the middle of a string applies to the next one only
        set_offset(3'd3);
        send_octet(8'h31, 1'b0);
        send_octet(8'h16, 1'b0);
        set_offset(3'd5);
        send_octet(8'h7f, 1'b1);
        send_octet(8'h32, 1'b1);
        set_offset(3'd1);
        send_octet(8'h0d, 1'b0);
        send_octet(8'h80, 1'b0);
        send_octet(8'h55, 1'b1);
        set_offset(3'd6);
        send_octet(8'h20, 1'b0);
        send_octet(8'h7e, 1'b0);
        send_octet(8'hc3, 1'b1);

        for (int p = 0; p < 8; p++) begin
            set_offset(3'(phase_offset[p]));
            sender_gaps = (p % 3 != 2);
            sent = 0;
            while (sent < PHASE_OCTETS) begin
                str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 6);
                for (int k = 0; k < str_len; k++) begin
                    send_octet(pick_symbol(), k == str_len - 1);
                end
                sent += str_len;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/hpack_pkg.sv
design/hpack_front.sv
design/hpack_queue.sv
design/hpack_back.sv
design/hpack_huffman_encoder.sv
design/hpack_checker.sv
test/hpack_huffman_encoder_checker.sv
test/hpack_huffman_encoder_tb.sv
